>>> src/thc_pkg.sv
// Shared types, constants and the arctangent table for the tilt-compensated heading block.
package thc_pkg;

  localparam int CORDIC_STAGES_DEF   = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 13;
  localparam int ATAN_LEN            = 24;
  localparam int QUEUE_DEPTH         = 2;

  localparam int TW = 32;  // sine and cosine, Q30
  localparam int ZW = 34;  // reduced angles, Q30
  localparam int FW = 40;  // angles before reduction, Q30
  localparam int PW = 48;  // field times trig products
  localparam int VW = 50;  // horizontal components and vectoring datapath
  localparam int QW = 6;   // turn count estimate
  localparam int DW = 58;  // degree conversion product

  localparam logic signed [FW-1:0] PI_Q30      = 40'sd3373259426;
  localparam logic signed [FW-1:0] HALF_PI_Q30 = 40'sd1686629713;
  localparam logic signed [FW-1:0] TWO_PI_Q30  = 40'sd6746518852;
  localparam logic signed [TW-1:0] GAIN_Q30    = 32'sd652032874;
  localparam logic signed [23:0]   DEG_PER_RAD_Q16 = 24'sd3754936;

  typedef struct packed {
    logic                 req;
    logic signed [15:0]   fx;
    logic signed [15:0]   fy;
    logic signed [15:0]   fz;
    logic signed [ZW-1:0] zp;
    logic signed [ZW-1:0] zr;
    logic                 np;
    logic                 nr;
  } thc_item_t;

  typedef struct packed {
    logic               v;
    logic               req;
    logic signed [15:0] fx;
    logic signed [15:0] fy;
    logic signed [15:0] fz;
  } thc_side_t;

  typedef struct packed {
    logic                 v;
    logic                 req;
    logic                 zero;
    logic signed [ZW-1:0] zang;
  } thc_tail_t;

  function automatic logic [TW-1:0] atan_q30(input logic [4:0] idx);
    logic [TW-1:0] a;
    unique case (idx)
      5'd0:    a = 32'd843314857;
      5'd1:    a = 32'd497837829;
      5'd2:    a = 32'd263043837;
      5'd3:    a = 32'd133525159;
      5'd4:    a = 32'd67021687;
      5'd5:    a = 32'd33543516;
      5'd6:    a = 32'd16775851;
      5'd7:    a = 32'd8388437;
      5'd8:    a = 32'd4194283;
      5'd9:    a = 32'd2097149;
      5'd10:   a = 32'd1048576;
      5'd11:   a = 32'd524288;
      5'd12:   a = 32'd262144;
      5'd13:   a = 32'd131072;
      5'd14:   a = 32'd65536;
      5'd15:   a = 32'd32768;
      5'd16:   a = 32'd16384;
      5'd17:   a = 32'd8192;
      5'd18:   a = 32'd4096;
      5'd19:   a = 32'd2048;
      5'd20:   a = 32'd1024;
      5'd21:   a = 32'd512;
      5'd22:   a = 32'd256;
      5'd23:   a = 32'd128;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

>>> src/tilt_compensated_heading.sv
// Top level of the tilt-compensated heading block: front part, queues and back part.
//
// The input side looks like a queue: drive the item fields and raise push; the beat is
// taken at a rising edge with push high and full low. Results come out of a queue: while
// empty is low the oldest heading and its zero_divisor flag are on the out_ ports, and
// the beat is taken at a rising edge with pop high. Every input beat gives one result
// beat, in order.
// The heading is atan(yH/xH) within +-90 degrees, in degrees Q7.8 when in_req_type is 0
// and in radians with ANGLE_FRAC_BITS fraction bits when it is 1.
// The latency from the input beat to empty going low is mostly set by the two pipelined
// CORDIC chains, one register per iteration. A new item is taken every cycle while results
// are drained.
// When the receiver stalls, the result queue fills, the back pipeline freezes, the queue
// between the front and back parts fills, and full rises after that; no beat is lost.
// Synchronous reset empties all queues and clears every pipeline valid bit.
module tilt_compensated_heading #(
  parameter int CORDIC_STAGES   = thc_pkg::CORDIC_STAGES_DEF,
  parameter int ANGLE_FRAC_BITS = thc_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic               in_req_type,
  input  logic signed [15:0] in_pitch_angle,
  input  logic signed [15:0] in_roll_angle,
  input  logic signed [15:0] in_field_x,
  input  logic signed [15:0] in_field_y,
  input  logic signed [15:0] in_field_z,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] out_heading,
  output logic               out_zero_divisor
);
  import thc_pkg::*;

  localparam int STAGES = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
  localparam int IW     = $bits(thc_item_t);

  logic      mid_push, mid_full, mid_pop, mid_empty;
  thc_item_t mid_wr, mid_rd;
  logic      res_push, res_full;
  logic signed [15:0] res_heading;
  logic      res_flag;
  logic [16:0] res_rd;

  thc_front #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_req_type(in_req_type), .in_pitch_angle(in_pitch_angle),
    .in_roll_angle(in_roll_angle), .in_field_x(in_field_x),
    .in_field_y(in_field_y), .in_field_z(in_field_z),
    .mid_push(mid_push), .mid_item(mid_wr), .mid_full(mid_full)
  );

  thc_fifo #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_mid_q (
    .clk(clk), .rst_n(rst_n), .push(mid_push), .wdata(mid_wr), .full(mid_full),
    .pop(mid_pop), .rdata(mid_rd), .empty(mid_empty)
  );

  thc_back #(.STAGES(STAGES), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .mid_empty(mid_empty), .mid_item(mid_rd),
    .mid_pop(mid_pop), .out_full(res_full), .out_push(res_push),
    .heading(res_heading), .zero_div(res_flag)
  );

  thc_fifo #(.WIDTH(17), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk(clk), .rst_n(rst_n), .push(res_push), .wdata({res_heading, res_flag}),
    .full(res_full), .pop(pop), .rdata(res_rd), .empty(empty)
  );

  assign out_heading      = res_rd[16:1];
  assign out_zero_divisor = res_rd[0];

endmodule

>>> src/thc_fifo.sv
// Small register queue used between the front and back parts and at the result side.
module thc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = thc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  import thc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> src/thc_front.sv
// Front part: accepts input beats and reduces both angles into the CORDIC range.
module thc_front #(
  parameter int ANGLE_FRAC_BITS = thc_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic               in_req_type,
  input  logic signed [15:0] in_pitch_angle,
  input  logic signed [15:0] in_roll_angle,
  input  logic signed [15:0] in_field_x,
  input  logic signed [15:0] in_field_y,
  input  logic signed [15:0] in_field_z,
  output logic               mid_push,
  output thc_pkg::thc_item_t mid_item,
  input  logic               mid_full
);
  import thc_pkg::*;

  localparam int K = 30 - ANGLE_FRAC_BITS;
  localparam logic [63:0] RECIP   = (64'd1 << (24 + K)) / 64'd6746518852;
  localparam logic [15:0] RECIP16 = RECIP[15:0];

  function automatic logic signed [FW-1:0] wrap_mod(input logic [16:0] mag, input logic sgn,
                                                   input logic [QW-1:0] q);
    logic [FW-1:0] a;
    logic [FW-1:0] r;
    a = FW'(mag) << K;
    r = a - (FW'(q) * FW'(TWO_PI_Q30));
    if (r >= FW'(TWO_PI_Q30)) begin
      r = r - FW'(TWO_PI_Q30);
    end
    return sgn ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [ZW:0] fold(input logic signed [FW-1:0] z);
    logic signed [FW-1:0] zz;
    logic                 neg;
    zz  = z;
    neg = 1'b0;
    if (zz > PI_Q30) begin
      zz = zz - TWO_PI_Q30;
    end else if (zz < -PI_Q30) begin
      zz = zz + TWO_PI_Q30;
    end
    if (zz > HALF_PI_Q30) begin
      zz  = zz - PI_Q30;
      neg = 1'b1;
    end else if (zz < -HALF_PI_Q30) begin
      zz  = zz + PI_Q30;
      neg = 1'b1;
    end
    return {neg, zz[ZW-1:0]};
  endfunction

  logic ce;
  logic f1_v_r, f2_v_r, f3_v_r;

  logic signed [16:0] pe, re;
  logic [16:0]        pm, rm;
  logic [33:0]        pprod, rprod;

  logic               f1_req_r;
  logic signed [15:0] f1_fx_r, f1_fy_r, f1_fz_r;
  logic [16:0]        f1_pm_r, f1_rm_r;
  logic               f1_ps_r, f1_rs_r;
  logic [QW-1:0]      f1_pq_r, f1_rq_r;

  logic                 f2_req_r;
  logic signed [15:0]   f2_fx_r, f2_fy_r, f2_fz_r;
  logic signed [FW-1:0] f2_zp_r, f2_zr_r;

  logic [ZW:0] pfold, rfold;
  thc_item_t   f3_item_r;

  assign ce       = !(f3_v_r && mid_full);
  assign full     = !ce;
  assign mid_push = f3_v_r && !mid_full;
  assign mid_item = f3_item_r;

  assign pe    = 17'(in_pitch_angle);
  assign re    = 17'(in_roll_angle);
  assign pm    = pe[16] ? 17'(-pe) : 17'(pe);
  assign rm    = re[16] ? 17'(-re) : 17'(re);
  assign pprod = 34'(pm) * 34'(RECIP16);
  assign rprod = 34'(rm) * 34'(RECIP16);
  assign pfold = fold(f2_zp_r);
  assign rfold = fold(f2_zr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
    end else if (ce) begin
      f1_v_r <= push;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      f1_req_r <= in_req_type;
      f1_fx_r  <= in_field_x;
      f1_fy_r  <= in_field_y;
      f1_fz_r  <= in_field_z;
      f1_pm_r  <= pm;
      f1_rm_r  <= rm;
      f1_ps_r  <= pe[16];
      f1_rs_r  <= re[16];
      f1_pq_r  <= pprod[24 +: QW];
      f1_rq_r  <= rprod[24 +: QW];

      f2_req_r <= f1_req_r;
      f2_fx_r  <= f1_fx_r;
      f2_fy_r  <= f1_fy_r;
      f2_fz_r  <= f1_fz_r;
      f2_zp_r  <= wrap_mod(f1_pm_r, f1_ps_r, f1_pq_r);
      f2_zr_r  <= wrap_mod(f1_rm_r, f1_rs_r, f1_rq_r);

      f3_item_r.req <= f2_req_r;
      f3_item_r.fx  <= f2_fx_r;
      f3_item_r.fy  <= f2_fy_r;
      f3_item_r.fz  <= f2_fz_r;
      f3_item_r.zp  <= pfold[ZW-1:0];
      f3_item_r.np  <= pfold[ZW];
      f3_item_r.zr  <= rfold[ZW-1:0];
      f3_item_r.nr  <= rfold[ZW];
    end
  end

endmodule

>>> src/thc_sincos.sv
// Pipelined rotation CORDIC that gives the sine and cosine of one reduced angle.
module thc_sincos #(
  parameter int STAGES = thc_pkg::CORDIC_STAGES_DEF
) (
  input  logic                         clk,
  input  logic                         ce,
  input  logic signed [thc_pkg::ZW-1:0] z_in,
  input  logic                         neg_in,
  output logic signed [thc_pkg::TW-1:0] sin_out,
  output logic signed [thc_pkg::TW-1:0] cos_out
);
  import thc_pkg::*;

  logic signed [TW-1:0] xs [STAGES+1];
  logic signed [TW-1:0] ys [STAGES+1];
  logic signed [ZW-1:0] zs [STAGES+1];
  logic                 ns [STAGES+1];

  assign xs[0] = GAIN_Q30;
  assign ys[0] = '0;
  assign zs[0] = z_in;
  assign ns[0] = neg_in;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [ZW-1:0] AT = ZW'(atan_q30(5'(i)));
    logic signed [TW-1:0] x_r, y_r;
    logic signed [ZW-1:0] z_r;
    logic                 n_r;

    always_ff @(posedge clk) begin
      if (ce) begin
        if (zs[i] >= 0) begin
          x_r <= xs[i] - (ys[i] >>> i);
          y_r <= ys[i] + (xs[i] >>> i);
          z_r <= zs[i] - AT;
        end else begin
          x_r <= xs[i] + (ys[i] >>> i);
          y_r <= ys[i] - (xs[i] >>> i);
          z_r <= zs[i] + AT;
        end
        n_r <= ns[i];
      end
    end

    assign xs[i+1] = x_r;
    assign ys[i+1] = y_r;
    assign zs[i+1] = z_r;
    assign ns[i+1] = n_r;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sin_out <= ns[STAGES] ? -ys[STAGES] : ys[STAGES];
      cos_out <= ns[STAGES] ? -xs[STAGES] : xs[STAGES];
    end
  end

endmodule

>>> src/thc_atan.sv
// Pipelined vectoring CORDIC that gives the arctangent of y over a positive x.
module thc_atan #(
  parameter int STAGES = thc_pkg::CORDIC_STAGES_DEF
) (
  input  logic                         clk,
  input  logic                         ce,
  input  logic signed [thc_pkg::VW-1:0] x_in,
  input  logic signed [thc_pkg::VW-1:0] y_in,
  output logic signed [thc_pkg::ZW-1:0] z_out
);
  import thc_pkg::*;

  logic signed [VW-1:0] xs [STAGES+1];
  logic signed [VW-1:0] ys [STAGES+1];
  logic signed [ZW-1:0] zs [STAGES+1];

  assign xs[0] = x_in;
  assign ys[0] = y_in;
  assign zs[0] = '0;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [ZW-1:0] AT = ZW'(atan_q30(5'(i)));
    logic signed [VW-1:0] x_r, y_r;
    logic signed [ZW-1:0] z_r;

    always_ff @(posedge clk) begin
      if (ce) begin
        if (ys[i] > 0) begin
          x_r <= xs[i] + (ys[i] >>> i);
          y_r <= ys[i] - (xs[i] >>> i);
          z_r <= zs[i] + AT;
        end else begin
          x_r <= xs[i] - (ys[i] >>> i);
          y_r <= ys[i] + (xs[i] >>> i);
          z_r <= zs[i] - AT;
        end
      end
    end

    assign xs[i+1] = x_r;
    assign ys[i+1] = y_r;
    assign zs[i+1] = z_r;
  end

  assign z_out = zs[STAGES];

endmodule

>>> src/thc_back.sv
// Back part: trig lanes, horizontal projection, arctangent and unit conversion.
module thc_back #(
  parameter int STAGES          = thc_pkg::CORDIC_STAGES_DEF,
  parameter int ANGLE_FRAC_BITS = thc_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               mid_empty,
  input  thc_pkg::thc_item_t mid_item,
  output logic               mid_pop,
  input  logic               out_full,
  output logic               out_push,
  output logic signed [15:0] heading,
  output logic               zero_div
);
  import thc_pkg::*;

  localparam int K = 30 - ANGLE_FRAC_BITS;
  localparam logic signed [ZW-1:0] RAD_HALF = ZW'(64'd1 << (K - 1));
  localparam logic signed [DW-1:0] DEG_HALF = DW'(64'd1 << 37);
  localparam logic signed [63:0]   TRIG_HALF = 64'sd536870912;

  logic ce;
  assign ce       = !out_full;
  assign mid_pop  = ce && !mid_empty;

  logic signed [TW-1:0] sin_p, cos_p, sin_r, cos_r;

  thc_sincos #(.STAGES(STAGES)) u_pitch (
    .clk(clk), .ce(ce), .z_in(mid_item.zp), .neg_in(mid_item.np),
    .sin_out(sin_p), .cos_out(cos_p)
  );

  thc_sincos #(.STAGES(STAGES)) u_roll (
    .clk(clk), .ce(ce), .z_in(mid_item.zr), .neg_in(mid_item.nr),
    .sin_out(sin_r), .cos_out(cos_r)
  );

  thc_side_t side_r [STAGES+1];
  thc_side_t sd;
  assign sd = side_r[STAGES];

  logic                 m1_v_r, m2_v_r, m3_v_r, m4_v_r, c_v_r, d1_v_r;
  logic                 m1_req_r, m2_req_r, m3_req_r, m4_req_r, c_req_r;
  logic signed [15:0]   m1_fx_r, m1_fz_r, m2_fx_r, m2_fz_r;
  logic signed [63:0]   m1_p1_r, m1_p2_r;
  logic signed [PW-1:0] m1_p3_r, m1_p4_r, m1_p5_r, m2_p5_r, m3_p5_r;
  logic signed [TW-1:0] m2_spsr_r, m2_srcp_r;
  logic signed [VW-1:0] m2_xh_r, m3_xh_r, m4_xh_r, m4_yh_r;
  logic signed [PW-1:0] m3_q1_r, m3_q2_r;
  logic                 c_zero_r;
  logic signed [VW-1:0] c_x_r, c_y_r;
  logic signed [ZW-1:0] c_zang_r;

  logic signed [ZW-1:0] vz;
  thc_atan #(.STAGES(STAGES)) u_atan (
    .clk(clk), .ce(ce), .x_in(c_x_r), .y_in(c_y_r), .z_out(vz)
  );

  thc_tail_t tail_r [STAGES];
  thc_tail_t td;
  assign td = tail_r[STAGES-1];

  logic signed [ZW-1:0] ang;
  logic                 d1_req_r, d1_zero_r;
  logic signed [ZW-1:0] d1_ang_r;
  logic signed [DW-1:0] d1_prod_r;
  logic signed [ZW-1:0] rad;
  logic signed [DW-1:0] deg;

  assign ang = td.zero ? td.zang : vz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= STAGES; j++) begin
        side_r[j].v <= 1'b0;
      end
      for (int j = 0; j < STAGES; j++) begin
        tail_r[j].v <= 1'b0;
      end
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
      m3_v_r <= 1'b0;
      m4_v_r <= 1'b0;
      c_v_r  <= 1'b0;
      d1_v_r <= 1'b0;
    end else if (ce) begin
      side_r[0].v   <= mid_pop;
      side_r[0].req <= mid_item.req;
      side_r[0].fx  <= mid_item.fx;
      side_r[0].fy  <= mid_item.fy;
      side_r[0].fz  <= mid_item.fz;
      for (int j = 1; j <= STAGES; j++) begin
        side_r[j] <= side_r[j-1];
      end
      m1_v_r         <= sd.v;
      m2_v_r         <= m1_v_r;
      m3_v_r         <= m2_v_r;
      m4_v_r         <= m3_v_r;
      c_v_r          <= m4_v_r;
      tail_r[0].v    <= c_v_r;
      tail_r[0].req  <= c_req_r;
      tail_r[0].zero <= c_zero_r;
      tail_r[0].zang <= c_zang_r;
      for (int j = 1; j < STAGES; j++) begin
        tail_r[j] <= tail_r[j-1];
      end
      d1_v_r <= td.v;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m1_req_r <= sd.req;
      m1_fx_r  <= sd.fx;
      m1_fz_r  <= sd.fz;
      m1_p1_r  <= 64'(sin_p) * 64'(sin_r);
      m1_p2_r  <= 64'(sin_r) * 64'(cos_p);
      m1_p3_r  <= PW'(sd.fx) * PW'(cos_p);
      m1_p4_r  <= PW'(sd.fz) * PW'(sin_p);
      m1_p5_r  <= PW'(sd.fy) * PW'(cos_r);

      m2_req_r  <= m1_req_r;
      m2_fx_r   <= m1_fx_r;
      m2_fz_r   <= m1_fz_r;
      m2_spsr_r <= TW'((m1_p1_r + TRIG_HALF) >>> 30);
      m2_srcp_r <= TW'((m1_p2_r + TRIG_HALF) >>> 30);
      m2_xh_r   <= VW'(m1_p3_r) + VW'(m1_p4_r);
      m2_p5_r   <= m1_p5_r;

      m3_req_r <= m2_req_r;
      m3_q1_r  <= PW'(m2_fx_r) * PW'(m2_spsr_r);
      m3_q2_r  <= PW'(m2_fz_r) * PW'(m2_srcp_r);
      m3_xh_r  <= m2_xh_r;
      m3_p5_r  <= m2_p5_r;

      m4_req_r <= m3_req_r;
      m4_xh_r  <= m3_xh_r;
      m4_yh_r  <= VW'(m3_q1_r) + VW'(m3_p5_r) - VW'(m3_q2_r);

      c_req_r  <= m4_req_r;
      c_zero_r <= (m4_xh_r == '0);
      c_x_r    <= m4_xh_r[VW-1] ? -m4_xh_r : m4_xh_r;
      c_y_r    <= m4_xh_r[VW-1] ? -m4_yh_r : m4_yh_r;
      if (m4_yh_r > 0) begin
        c_zang_r <= ZW'(HALF_PI_Q30);
      end else if (m4_yh_r < 0) begin
        c_zang_r <= -ZW'(HALF_PI_Q30);
      end else begin
        c_zang_r <= '0;
      end

      d1_req_r  <= td.req;
      d1_zero_r <= td.zero;
      d1_ang_r  <= ang;
      d1_prod_r <= DW'(ang) * DW'(DEG_PER_RAD_Q16);
    end
  end

  assign rad      = (d1_ang_r + RAD_HALF) >>> K;
  assign deg      = (d1_prod_r + DEG_HALF) >>> 38;
  assign out_push = d1_v_r && ce;
  assign zero_div = d1_zero_r;

  always_comb begin
    if (d1_req_r) begin
      if (rad > ZW'(32767)) begin
        heading = 16'sh7fff;
      end else if (rad < -ZW'(32768)) begin
        heading = -16'sh8000;
      end else begin
        heading = rad[15:0];
      end
    end else begin
      if (deg > DW'(32767)) begin
        heading = 16'sh7fff;
      end else if (deg < -DW'(32768)) begin
        heading = -16'sh8000;
      end else begin
        heading = deg[15:0];
      end
    end
  end

endmodule
